### rtl/core/llma_pkg.sv
// ---------------------------------------------------------------------------
// llma_pkg
// Shared types, codes, constants and the control store of the light level
// moving average threshold unit.
// ---------------------------------------------------------------------------
package llma_pkg;

	localparam int STEP_W = 4;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_CAL    = 2'd1;
	localparam logic [1:0] FUNC_DETECT = 2'd2;
	localparam logic [1:0] FUNC_NOP    = 2'd3;

	localparam logic [1:0] REG_PERCENT  = 2'd0;
	localparam logic [1:0] REG_INTERVAL = 2'd1;
	localparam logic [1:0] REG_WINLEN   = 2'd2;

	localparam logic [6:0]  RST_PERCENT  = 7'd80;
	localparam logic [15:0] RST_INTERVAL = 16'd1000;
	localparam logic [4:0]  RST_WINLEN   = 5'd8;

	// floor(x / 100) as (x * 5243) >> 19, exact for x below 2^15
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [9:0] ADC_FULL = 10'd1023;

	localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
	localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
	localparam logic [STEP_W-1:0] ST_WRITE    = 4'd2;
	localparam logic [STEP_W-1:0] ST_SUM_CLR  = 4'd3;
	localparam logic [STEP_W-1:0] ST_SUM_ACC  = 4'd4;
	localparam logic [STEP_W-1:0] ST_DIV_INIT = 4'd5;
	localparam logic [STEP_W-1:0] ST_DIV_STEP = 4'd6;
	localparam logic [STEP_W-1:0] ST_MUL      = 4'd7;
	localparam logic [STEP_W-1:0] ST_THR      = 4'd8;
	localparam logic [STEP_W-1:0] ST_EMIT     = 4'd9;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_WRITE,
		OP_SUM_CLR,
		OP_SUM_ACC,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_MUL,
		OP_THR,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_IN_ACCEPT,
		C_NO_WRITE,
		C_SUM_MORE,
		C_DIV_MORE,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic              stay;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic no_write;
		logic sum_last;
		logic div_last;
	} dp_status_t;

	typedef struct packed {
		logic in_accept;
		logic out_free;
		dp_status_t dp;
	} seq_cond_t;

	typedef struct packed {
		logic       window_updated;
		logic [7:0] average;
		logic [7:0] threshold;
		logic       dark;
	} result_t;

	function automatic ctl_t ctl_rom(input logic [STEP_W-1:0] step);
		ctl_t w;
		w = '{op: OP_NONE, cond: C_IN_ACCEPT, stay: 1'b1, target: ST_DISPATCH};
		unique case (step)
			ST_IDLE:     w = '{op: OP_NONE,     cond: C_IN_ACCEPT, stay: 1'b1, target: ST_DISPATCH};
			ST_DISPATCH: w = '{op: OP_NONE,     cond: C_NO_WRITE,  stay: 1'b0, target: ST_EMIT};
			ST_WRITE:    w = '{op: OP_WRITE,    cond: C_NEVER,     stay: 1'b0, target: ST_IDLE};
			ST_SUM_CLR:  w = '{op: OP_SUM_CLR,  cond: C_NEVER,     stay: 1'b0, target: ST_IDLE};
			ST_SUM_ACC:  w = '{op: OP_SUM_ACC,  cond: C_SUM_MORE,  stay: 1'b0, target: ST_SUM_ACC};
			ST_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEVER,     stay: 1'b0, target: ST_IDLE};
			ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  stay: 1'b0, target: ST_DIV_STEP};
			ST_MUL:      w = '{op: OP_MUL,      cond: C_NEVER,     stay: 1'b0, target: ST_IDLE};
			ST_THR:      w = '{op: OP_THR,      cond: C_NEVER,     stay: 1'b0, target: ST_IDLE};
			ST_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_FREE,  stay: 1'b1, target: ST_IDLE};
			default:     w = '{op: OP_NONE,     cond: C_NEVER,     stay: 1'b0, target: ST_IDLE};
		endcase
		return w;
	endfunction

	// floor(x * 255 / 1023) with one correction step
	function automatic logic [7:0] scale_level(input logic [9:0] x);
		logic [17:0] y;
		logic [7:0]  q0;
		logic [10:0] r;
		y  = {x, 8'd0} - {8'd0, x};
		q0 = y[17:10];
		r  = {1'b0, y[9:0]} + {3'd0, q0};
		return (r >= {1'b0, ADC_FULL}) ? q0 + 8'd1 : q0;
	endfunction

endpackage

### rtl/core/llma_ram.sv
// ---------------------------------------------------------------------------
// llma_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module llma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/llma_seq.sv
// ---------------------------------------------------------------------------
// llma_seq
// Step counter and control store: fetches one control word per step and
// resolves conditional jumps.
// ---------------------------------------------------------------------------
module llma_seq
	import llma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  seq_cond_t         cond,
	output ctl_t              ctl,
	output logic [STEP_W-1:0] step
);

	logic [STEP_W-1:0] step_q;
	logic              take;

	assign ctl  = ctl_rom(step_q);
	assign step = step_q;

	always_comb begin
		unique case (ctl.cond)
			C_NEVER:     take = 1'b0;
			C_IN_ACCEPT: take = cond.in_accept;
			C_NO_WRITE:  take = cond.dp.no_write;
			C_SUM_MORE:  take = !cond.dp.sum_last;
			C_DIV_MORE:  take = !cond.dp.div_last;
			C_OUT_FREE:  take = cond.out_free;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (take) begin
			step_q <= ctl.target;
		end else if (!ctl.stay) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

### rtl/core/llma_dp.sv
// ---------------------------------------------------------------------------
// llma_dp
// Datapath: sample window, summation, serial divider, percent scaling and
// dark comparison, driven by the control word.
// ---------------------------------------------------------------------------
module llma_dp
	import llma_pkg::*;
#(
	parameter int WINDOW_MAX = 16,
	localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int LEN_W = $clog2(WINDOW_MAX + 1),
	localparam int SUM_W = $clog2(WINDOW_MAX) + 8,
	localparam int DW    = $clog2(SUM_W)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic             in_load,
	input  logic [1:0]       in_func,
	input  logic [9:0]       in_adc,
	input  logic [31:0]      in_time,
	input  logic [6:0]       percent,
	input  logic [15:0]      interval,
	input  logic [LEN_W-1:0] win_len,
	output dp_status_t       status,
	output result_t          result
);

	logic [1:0]       func_q;
	logic [7:0]       level_q;
	logic [31:0]      time_q;
	logic [31:0]      last_ms_q;
	logic [AW-1:0]    slot_q;
	logic [WINDOW_MAX-1:0] valid_q;
	logic             upd_q;
	logic [AW-1:0]    sidx_q;
	logic [SUM_W-1:0] acc_q;
	logic [LEN_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [DW-1:0]    dcnt_q;
	logic [14:0]      prod_q;
	logic [7:0]       mean_q;
	logic [7:0]       thr_q;
	logic             rvalid_s1;

	logic [AW-1:0]    slot_sel;
	logic [LEN_W-1:0] slot_inc;
	logic [AW-1:0]    slot_next;
	logic [AW-1:0]    raddr;
	logic [7:0]       rdata;
	logic             we;
	logic [31:0]      elapsed;
	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   trial_sub;
	logic             trial_ge;
	logic [27:0]      recip;
	logic [8:0]       thr_raw;

	assign slot_sel  = (LEN_W'(slot_q) < win_len) ? slot_q : '0;
	assign slot_inc  = LEN_W'(slot_sel) + LEN_W'(1);
	assign slot_next = (slot_inc >= win_len) ? '0 : AW'(slot_inc);
	assign we        = (ctl.op == OP_WRITE);
	assign raddr     = (ctl.op == OP_SUM_ACC) ? sidx_q + AW'(1) : '0;
	assign elapsed   = time_q - last_ms_q;

	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign trial_ge  = (trial >= {1'b0, win_len});
	assign trial_sub = trial - {1'b0, win_len};

	assign recip   = 28'(prod_q) * 28'(RECIP_100);
	assign thr_raw = recip[RECIP_SHIFT +: 9];

	assign status.no_write = (func_q == FUNC_DETECT) || (func_q == FUNC_NOP)
		|| ((func_q == FUNC_CAL) && !(elapsed > 32'(interval)));
	assign status.sum_last = (LEN_W'(sidx_q) == win_len - LEN_W'(1));
	assign status.div_last = (dcnt_q == DW'(SUM_W - 1));

	assign result.dark           = (func_q == FUNC_DETECT) && (level_q < thr_q);
	assign result.threshold      = thr_q;
	assign result.average        = mean_q;
	assign result.window_updated = upd_q;

	llma_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_MAX)
	) u_window (
		.clk   (clk),
		.we    (we),
		.waddr (slot_sel),
		.wdata (level_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ms_q <= '0;
			slot_q    <= '0;
			valid_q   <= '0;
			mean_q    <= '0;
			thr_q     <= '0;
			upd_q     <= 1'b0;
			func_q    <= FUNC_NOP;
		end else begin
			if (in_load) begin
				func_q <= in_func;
				upd_q  <= 1'b0;
			end
			unique case (ctl.op)
				OP_WRITE: begin
					valid_q[slot_sel] <= 1'b1;
					slot_q            <= slot_next;
					upd_q             <= 1'b1;
					if (func_q == FUNC_CAL) begin
						last_ms_q <= time_q;
					end
				end
				OP_MUL:  mean_q <= quo_q[7:0];
				OP_THR:  thr_q  <= (thr_raw > 9'd255) ? 8'd255 : thr_raw[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rvalid_s1 <= valid_q[raddr];
		if (in_load) begin
			level_q <= scale_level(in_adc);
			time_q  <= in_time;
		end
		unique case (ctl.op)
			OP_SUM_CLR: begin
				sidx_q <= '0;
				acc_q  <= '0;
			end
			OP_SUM_ACC: begin
				sidx_q <= sidx_q + AW'(1);
				acc_q  <= acc_q + (rvalid_s1 ? SUM_W'(rdata) : '0);
			end
			OP_DIV_INIT: begin
				quo_q  <= acc_q;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			OP_DIV_STEP: begin
				dcnt_q <= dcnt_q + DW'(1);
				quo_q  <= {quo_q[SUM_W-2:0], trial_ge};
				rem_q  <= trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
			end
			OP_MUL:  prod_q <= 15'(quo_q[7:0]) * 15'(percent);
			default: ;
		endcase
	end

endmodule

### rtl/core/light_level_moving_average_threshold_unit.sv
// ---------------------------------------------------------------------------
// light_level_moving_average_threshold_unit
// Moving average of scaled light samples with a percent threshold for dark
// detection, run by a small microcoded sequencer.
// ---------------------------------------------------------------------------
// One item is worked at a time and gives one result. A detect item, a no-op
// item or a calibrate item that falls inside the update interval goes from
// dispatch straight to the result step. An item that writes the window also
// sums it and divides the sum, where SUM_W = clog2(WINDOW_MAX) + 8: the sum
// walks the window RAM through its single read port, one entry a cycle, and
// the average comes from a restoring divider giving one quotient bit a cycle.
// A finished result sits in the output register while the next item is taken
// in.
// ---------------------------------------------------------------------------
module light_level_moving_average_threshold_unit
	import llma_pkg::*;
#(
	parameter int WINDOW_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // adc_sample, time_ms, zero fill
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // dark, threshold, average, window_updated, zero fill
);

	localparam int LEN_W = $clog2(WINDOW_MAX + 1);

	logic [6:0]  percent_q;
	logic [15:0] interval_q;
	logic [4:0]  winlen_q;
	logic        m_tvalid_q;
	result_t     result_q;

	logic              cfg_wr;
	logic [LEN_W-1:0]  win_len;
	logic              in_accept;
	logic              out_free;
	ctl_t              ctl;
	logic [STEP_W-1:0] step;
	seq_cond_t         cond;
	dp_status_t        status;
	result_t           result;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign s_tready  = (step == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {6'd0, result_q};

	always_comb begin
		if (winlen_q == 5'd0) begin
			win_len = LEN_W'(1);
		end else if (32'(winlen_q) > 32'(WINDOW_MAX)) begin
			win_len = LEN_W'(WINDOW_MAX);
		end else begin
			win_len = LEN_W'(winlen_q);
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PERCENT:  prdata = {25'd0, percent_q};
			REG_INTERVAL: prdata = {16'd0, interval_q};
			REG_WINLEN:   prdata = {27'd0, winlen_q};
			default:      prdata = '0;
		endcase
	end

	assign cond = '{in_accept: in_accept, out_free: out_free, dp: status};

	llma_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctl    (ctl),
		.step   (step)
	);

	llma_dp #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_load  (in_accept),
		.in_func  (s_tuser),
		.in_adc   (s_tdata[9:0]),
		.in_time  (s_tdata[41:10]),
		.percent  (percent_q),
		.interval (interval_q),
		.win_len  (win_len),
		.status   (status),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			percent_q  <= RST_PERCENT;
			interval_q <= RST_INTERVAL;
			winlen_q   <= RST_WINLEN;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_PERCENT:  percent_q  <= pwdata[6:0];
					REG_INTERVAL: interval_q <= pwdata[15:0];
					REG_WINLEN:   winlen_q   <= pwdata[4:0];
					default:      ;
				endcase
			end
			if ((ctl.op == OP_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl.op == OP_EMIT) && out_free) begin
			result_q <= result;
		end
	end

endmodule

### rtl/core/llma_checker.sv
// ---------------------------------------------------------------------------
// llma_checker
// Port level checks of the light level moving average threshold unit.
// ---------------------------------------------------------------------------
module llma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// one item at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again straight after a transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// dark needs a non-zero threshold
	a_dark_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] != 8'd0))
		else $error("dark reported with zero threshold");

	// a detect never writes the window
	a_dark_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[17]))
		else $error("dark and window update in one result");

endmodule

bind light_level_moving_average_threshold_unit llma_checker u_llma_checker (.*);

### tb/light_level_moving_average_threshold_unit_tb.sv
// ---------------------------------------------------------------------------
// light_level_moving_average_threshold_unit_tb
// Self-checking bench for the light level moving average threshold unit: a
// queue-fed stream driver, a stream monitor comparing each result field by
// field with a cycle-free model of the window, average and threshold, and
// register writes over the APB port between phases of directed and random
// load, calibrate, detect and no-op traffic under varying back-pressure.
// ---------------------------------------------------------------------------
module light_level_moving_average_threshold_unit_tb
	import llma_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_MAX     = 16;
	localparam int CYCLE_LIMIT = 900000;
	localparam int SEGMENTS    = 15;
	localparam int SEG_ITEMS   = 105;

	typedef struct {
		logic [1:0]  func;
		logic [9:0]  adc;
		logic [31:0] ms;
	} light_item_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // adc_sample, time_ms, zero fill
	logic [1:0]  s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // dark, threshold, average, window_updated, zero fill

	light_item_t sample_queue[$];
	result_t     pending_light_results[$];

	int src_idle_pct;
	int sink_idle_pct;
	int mismatches;
	int cycle_count;
	logic [31:0] ms_now;

	// model of the block
	logic [6:0]  cfg_percent;
	logic [15:0] cfg_interval;
	logic [4:0]  cfg_winlen;
	logic [7:0]  win_mem[WIN_MAX];
	int          win_slot;
	int          win_fill;
	int          win_sum;
	logic [7:0]  mean_lvl;
	logic [7:0]  dark_thr;
	logic [31:0] last_cal_ms;

	light_level_moving_average_threshold_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int window_len_used();
		if (cfg_winlen == 5'd0)
			return 1;
		if (cfg_winlen > WIN_MAX)
			return WIN_MAX;
		return int'(cfg_winlen);
	endfunction

	function automatic void push_level(input logic [7:0] lvl);
		int len;
		int sl;
		int t;
		len = window_len_used();
		sl = (win_slot < len) ? win_slot : 0;
		win_mem[sl] = lvl;
		sl = sl + 1;
		win_slot = (sl >= len) ? 0 : sl;
		win_fill = (win_fill < len) ? win_fill + 1 : len;
		win_sum = 0;
		for (int i = 0; i < len; i++)
			win_sum += int'(win_mem[i]);
		mean_lvl = 8'((win_sum / len) & 255);
		t = int'(mean_lvl) * int'(cfg_percent) / 100;
		dark_thr = (t > 255) ? 8'd255 : 8'(t);
	endfunction

	function automatic result_t predict_light_result(input logic [1:0] func,
			input logic [9:0] adc, input logic [31:0] now);
		result_t r;
		logic [7:0] lvl;
		logic [31:0] gap;
		lvl = 8'((int'(adc) * 255) / 1023);
		r.dark = 1'b0;
		r.window_updated = 1'b0;
		case (func)
			FUNC_LOAD: begin
				push_level(lvl);
				r.window_updated = 1'b1;
			end
			FUNC_CAL: begin
				gap = now - last_cal_ms;
				if (gap > {16'd0, cfg_interval}) begin
					last_cal_ms = now;
					push_level(lvl);
					r.window_updated = 1'b1;
				end
			end
			FUNC_DETECT: r.dark = (lvl < dark_thr);
			default: ;
		endcase
		r.threshold = dark_thr;
		r.average = mean_lvl;
		return r;
	endfunction

	// stream driver and input-side prediction
	always @(posedge clk or negedge arst_n) begin : drive_items
		light_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= FUNC_NOP;
			for (int i = 0; i < WIN_MAX; i++)
				win_mem[i] = 8'd0;
			win_slot = 0;
			win_fill = 0;
			win_sum = 0;
			mean_lvl = 8'd0;
			dark_thr = 8'd0;
			last_cal_ms = 32'd0;
		end else begin
			if (s_tvalid && s_tready)
				pending_light_results.push_back(
					predict_light_result(s_tuser, s_tdata[9:0], s_tdata[41:10]));
			if (!s_tvalid || s_tready) begin
				if (sample_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					it = sample_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= it.func;
					s_tdata <= {6'd0, it.ms, it.adc};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// register writes seen by the model
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_percent <= RST_PERCENT;
			cfg_interval <= RST_INTERVAL;
			cfg_winlen <= RST_WINLEN;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_PERCENT:  cfg_percent <= pwdata[6:0];
				REG_INTERVAL: cfg_interval <= pwdata[15:0];
				REG_WINLEN:   cfg_winlen <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	task automatic note_mismatch(input string what, input int exp_v, input int got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin : watch_results
		result_t want;
		result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				if (pending_light_results.size() == 0) begin
					note_mismatch("unexpected result transfer", 0, int'(m_tdata));
				end else begin
					want = pending_light_results.pop_front();
					if (got.dark !== want.dark)
						note_mismatch("dark", want.dark, got.dark);
					if (got.threshold !== want.threshold)
						note_mismatch("threshold", want.threshold, got.threshold);
					if (got.average !== want.average)
						note_mismatch("average", want.average, got.average);
					if (got.window_updated !== want.window_updated)
						note_mismatch("window_updated", want.window_updated,
							got.window_updated);
					if (m_tdata[23:18] !== 6'd0)
						note_mismatch("zero fill", 0, int'(m_tdata[23:18]));
				end
			end
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic add_item(input logic [1:0] func, input logic [9:0] adc,
			input logic [31:0] ms);
		light_item_t it;
		it.func = func;
		it.adc = adc;
		it.ms = ms;
		sample_queue.push_back(it);
	endtask

	// sampled away from the rising edge so queue, valid and pending agree
	task automatic wait_drained();
		while (sample_queue.size() > 0 || s_tvalid || pending_light_results.size() > 0)
			@(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic advance_ms(input int interval);
		int r;
		r = $urandom_range(99);
		if (r < 55)
			ms_now += $urandom_range(0, 3);
		else if (r < 85)
			ms_now += interval + $urandom_range(0, 2);
		else if (r < 97)
			ms_now += $urandom_range(0, 2 * interval + 10);
		else
			ms_now = $urandom;
	endtask

	task automatic random_segment(input int interval, input int len);
		int r;
		logic [1:0] f;
		// a couple of items before any window write: stale average must hold
		for (int i = 0; i < 2; i++) begin
			advance_ms(interval);
			add_item($urandom_range(0, 1) ? FUNC_DETECT : FUNC_NOP,
				10'($urandom_range(1023)), ms_now);
		end
		for (int i = 0; i < len; i++) begin
			advance_ms(interval);
			add_item(FUNC_LOAD, 10'($urandom_range(1023)), ms_now);
		end
		for (int i = 0; i < SEG_ITEMS - len - 2; i++) begin
			advance_ms(interval);
			r = $urandom_range(99);
			if (r < 25)
				f = FUNC_LOAD;
			else if (r < 58)
				f = FUNC_CAL;
			else if (r < 94)
				f = FUNC_DETECT;
			else
				f = FUNC_NOP;
			add_item(f, 10'($urandom_range(1023)), ms_now);
		end
	endtask

	initial begin
		int pct;
		int ivl;
		int wl;
		int eff;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		src_idle_pct = 7;
		sink_idle_pct = 53;
		mismatches = 0;
		cycle_count = 0;
		ms_now = 32'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: partial window, extremes, interval boundary, time wrap
		add_item(FUNC_DETECT, 10'd0, 32'd0);
		add_item(FUNC_LOAD, 10'd1023, 32'd0);
		add_item(FUNC_DETECT, 10'd0, 32'd1);
		add_item(FUNC_LOAD, 10'd0, 32'hFFFF_FFFF);
		add_item(FUNC_LOAD, 10'd511, 32'd2);
		add_item(FUNC_LOAD, 10'd512, 32'd3);
		for (int i = 0; i < 5; i++)
			add_item(FUNC_LOAD, 10'd1023 - 10'(i), 32'd4);
		add_item(FUNC_LOAD, 10'd900, 32'd5);
		add_item(FUNC_DETECT, 10'd1023, 32'd6);
		add_item(FUNC_DETECT, 10'd700, 32'd6);
		add_item(FUNC_CAL, 10'd0, 32'd500);
		add_item(FUNC_CAL, 10'd0, 32'd1000);
		add_item(FUNC_CAL, 10'd0, 32'd1001);
		add_item(FUNC_CAL, 10'd300, 32'd2001);
		add_item(FUNC_CAL, 10'd300, 32'd2002);
		add_item(FUNC_NOP, 10'd1023, 32'hAAAA_5555);
		add_item(FUNC_CAL, 10'd1023, 32'hFFFF_FFFF);
		add_item(FUNC_CAL, 10'd1023, 32'd999);
		add_item(FUNC_CAL, 10'd1023, 32'd1000);
		add_item(FUNC_DETECT, 10'd200, 32'd0);
		add_item(FUNC_DETECT, 10'd0, 32'h5555_AAAA);
		wait_drained();
		ms_now = 32'd1000;

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 5) begin
				src_idle_pct = 53;
				sink_idle_pct = 7;
			end else if (seg == 10) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			case (seg)
				0: begin pct = 0;   ivl = 0;     wl = 1;  end
				1: begin pct = 100; ivl = 65535; wl = 16; end
				2: begin pct = 127; ivl = 1;     wl = 0;  end
				3: begin pct = 101; ivl = 2;     wl = 31; end
				4: begin pct = 50;  ivl = 3;     wl = 17; end
				default: begin
					pct = ($urandom_range(9) == 0) ? $urandom_range(101, 127)
						: $urandom_range(0, 100);
					ivl = ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 40);
					wl = ($urandom_range(9) == 0) ? $urandom_range(0, 31)
						: $urandom_range(1, 16);
				end
			endcase
			if (seg == 7)
				ms_now = 32'hFFFF_FF00;
			apb_write(REG_PERCENT, 32'(pct));
			apb_write(REG_INTERVAL, 32'(ivl));
			apb_write(REG_WINLEN, 32'(wl));
			eff = (wl == 0) ? 1 : (wl > WIN_MAX) ? WIN_MAX : wl;
			random_segment(ivl, eff);
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
